/* hw/rtl/psu_pkg.sv */
package psu_pkg;

   localparam int MAX_WIDTH_DEF = 4096;
   localparam int BPP_DEF       = 3;
   localparam int RAW_W         = 8;
   localparam int LINE_W        = 14;
   localparam int LINE_RESET    = 3;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_kind_type;

   typedef struct packed {
      logic [RAW_W-1:0] raw_byte;
      filter_kind_type  kind;
      logic             first_row;
      logic             fresh;
      logic             last;
   } psu_op_type;

   function automatic int row_cap(int max_width, int bpp);
      return max_width * bpp;
   endfunction

   function automatic int addr_w(int cap);
      return (cap > 1) ? $clog2(cap) : 1;
   endfunction

endpackage

/* hw/rtl/psu_if.sv */
interface psu_req_if;
   import psu_pkg::*;
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] raw_byte;
   logic             image_start;
   modport source (output valid, output raw_byte, output image_start, input ready);
   modport sink (input valid, input raw_byte, input image_start, output ready);
endinterface

interface psu_rsp_if;
   import psu_pkg::*;
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] pixel_byte;
   logic             line_end;
   modport source (output valid, output pixel_byte, output line_end, input ready);
   modport sink (input valid, input pixel_byte, input line_end, output ready);
endinterface

interface psu_csr_if;
   import psu_pkg::*;
   logic              valid;
   logic              ready;
   logic [LINE_W-1:0] line_bytes;
   modport source (output valid, output line_bytes, input ready);
   modport sink (input valid, input line_bytes, output ready);
endinterface

/* hw/rtl/psu_seq.sv */
module psu_seq #(
   parameter int MAX_WIDTH       = psu_pkg::MAX_WIDTH_DEF,
   parameter int BYTES_PER_PIXEL = psu_pkg::BPP_DEF,
   localparam int CAP = psu_pkg::row_cap(MAX_WIDTH, BYTES_PER_PIXEL),
   localparam int AW  = psu_pkg::addr_w(CAP)
) (
   input  logic                clock,
   input  logic                reset,
   psu_req_if.sink             req_ch,
   psu_csr_if.sink             csr_ch,
   input  logic                s1_ready,
   output logic                ld,
   output psu_pkg::psu_op_type op,
   output logic [AW-1:0]       rd_addr
);
   import psu_pkg::*;

   localparam int LW = AW + 1;
   localparam int CW = (LW > LINE_W) ? LW : LINE_W;
   localparam logic [LW-1:0] LEN_RESET = (LINE_RESET > CAP) ? LW'(CAP) : LW'(LINE_RESET);

   function automatic logic [LW-1:0] eff_len(logic [LINE_W-1:0] v);
      logic [CW-1:0] w;
      w = CW'(v);
      if (w == '0) w = CW'(1);
      if (w > CW'(CAP)) w = CW'(CAP);
      return LW'(w);
   endfunction

   logic [LW-1:0]   len_ff, len_in;
   logic            awaiting_ff, awaiting_in;
   logic            first_row_ff, first_row_in;
   logic [AW-1:0]   column_ff, column_in;
   filter_kind_type kind_ff, kind_in;
   logic            fresh_ff, fresh_in;

   logic            accept;
   logic            start_line;
   logic [AW-1:0]   col;
   logic            last;

   assign req_ch.ready = s1_ready;
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && s1_ready;
   assign start_line   = req_ch.image_start || awaiting_ff;
   assign col          = (LW'(column_ff) >= len_ff) ? AW'(len_ff - LW'(1)) : column_ff;
   assign last         = (LW'(col) + LW'(1)) >= len_ff;
   assign ld           = accept && !start_line;
   assign rd_addr      = col;

   always_comb begin
      op.raw_byte  = req_ch.raw_byte;
      op.kind      = kind_ff;
      op.first_row = first_row_ff;
      op.fresh     = fresh_ff;
      op.last      = last;
   end

   always_comb begin
      len_in       = len_ff;
      awaiting_in  = awaiting_ff;
      first_row_in = first_row_ff;
      column_in    = column_ff;
      kind_in      = kind_ff;
      fresh_in     = fresh_ff;
      if (csr_ch.valid) begin
         len_in = eff_len(csr_ch.line_bytes);
      end
      if (accept) begin
         if (start_line) begin
            // filter type word, unknown types fall back to none
            if (req_ch.raw_byte <= {(RAW_W-3)'(0), FILT_PAETH}) begin
               kind_in = filter_kind_type'(req_ch.raw_byte[2:0]);
            end else begin
               kind_in = FILT_NONE;
            end
            awaiting_in  = 1'b0;
            column_in    = '0;
            fresh_in     = 1'b1;
            first_row_in = first_row_ff || req_ch.image_start;
         end else begin
            fresh_in = 1'b0;
            if (last) begin
               awaiting_in  = 1'b1;
               first_row_in = 1'b0;
               column_in    = '0;
            end else begin
               column_in = AW'(col + AW'(1));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LEN_RESET;
         awaiting_ff  <= 1'b1;
         first_row_ff <= 1'b1;
         column_ff    <= '0;
         kind_ff      <= FILT_NONE;
         fresh_ff     <= 1'b1;
      end else begin
         len_ff       <= len_in;
         awaiting_ff  <= awaiting_in;
         first_row_ff <= first_row_in;
         column_ff    <= column_in;
         kind_ff      <= kind_in;
         fresh_ff     <= fresh_in;
      end
   end

   a_last_rearms: assert property (@(posedge clock) disable iff (reset)
      ld && last |=> awaiting_ff && !first_row_ff)
      else $error("line end did not rearm filter word");

   a_filter_starts_line: assert property (@(posedge clock) disable iff (reset)
      accept && start_line |=> !awaiting_ff && fresh_ff && column_ff == '0)
      else $error("filter word did not start a line");

   a_addr_in_line: assert property (@(posedge clock) disable iff (reset)
      ld |-> LW'(rd_addr) < len_ff)
      else $error("row read beyond line length");

endmodule

/* hw/rtl/psu_recon.sv */
module psu_recon #(
   parameter int MAX_WIDTH       = psu_pkg::MAX_WIDTH_DEF,
   parameter int BYTES_PER_PIXEL = psu_pkg::BPP_DEF,
   localparam int CAP = psu_pkg::row_cap(MAX_WIDTH, BYTES_PER_PIXEL),
   localparam int AW  = psu_pkg::addr_w(CAP)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                ld,
   input  psu_pkg::psu_op_type op_in,
   input  logic [AW-1:0]       rd_addr,
   output logic                s1_ready,
   psu_rsp_if.source           rsp_ch
);
   import psu_pkg::*;

   logic [RAW_W-1:0] row_mem [0:CAP-1];
   logic [RAW_W-1:0] rd_data_ff;
   logic             fwd_ff, fwd_in;
   logic [RAW_W-1:0] fwd_data_ff;

   logic             s1_valid_ff, s1_valid_in;
   psu_op_type       s1_op_ff;
   logic [AW-1:0]    s1_col_ff;

   logic [RAW_W-1:0] left_ff [BYTES_PER_PIXEL];
   logic [RAW_W-1:0] left_in [BYTES_PER_PIXEL];
   logic [RAW_W-1:0] up_ff [BYTES_PER_PIXEL];
   logic [RAW_W-1:0] up_in [BYTES_PER_PIXEL];
   logic [RAW_W-1:0] left_eff [BYTES_PER_PIXEL];
   logic [RAW_W-1:0] up_eff [BYTES_PER_PIXEL];

   logic             rsp_valid_ff, rsp_valid_in;
   logic [RAW_W-1:0] rsp_pixel_ff;
   logic             rsp_end_ff;

   logic             can_adv;
   logic             wr_en;
   logic [RAW_W-1:0] a, b, c, b_mem;
   logic [RAW_W:0]   sum_ab;
   logic signed [9:0] sa, sb, sc, dpa, dpb, dpc;
   logic [9:0]       pa, pb, pc;
   logic [RAW_W-1:0] pred, paeth, pix;

   assign can_adv  = !rsp_valid_ff || rsp_ch.ready;
   assign s1_ready = !s1_valid_ff || can_adv;
   assign wr_en    = s1_valid_ff && can_adv;
   assign fwd_in   = wr_en && (rd_addr == s1_col_ff);

   assign b_mem = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign b     = s1_op_ff.first_row ? '0 : b_mem;

   always_comb begin
      for (int i = 0; i < BYTES_PER_PIXEL; i++) begin
         left_eff[i] = s1_op_ff.fresh ? '0 : left_ff[i];
         up_eff[i]   = s1_op_ff.fresh ? '0 : up_ff[i];
      end
   end

   assign a = left_eff[0];
   assign c = up_eff[0];

   // paeth distances at full width
   always_comb begin
      sa  = signed'({2'b00, a});
      sb  = signed'({2'b00, b});
      sc  = signed'({2'b00, c});
      dpa = sb - sc;
      dpb = sa - sc;
      dpc = sa + sb - sc - sc;
      pa  = dpa[9] ? 10'(-dpa) : 10'(dpa);
      pb  = dpb[9] ? 10'(-dpb) : 10'(dpb);
      pc  = dpc[9] ? 10'(-dpc) : 10'(dpc);
      if (pa <= pb && pa <= pc) begin
         paeth = a;
      end else if (pb <= pc) begin
         paeth = b;
      end else begin
         paeth = c;
      end
   end

   assign sum_ab = {1'b0, a} + {1'b0, b};

   always_comb begin
      case (s1_op_ff.kind)
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG:   pred = sum_ab[RAW_W:1];
         FILT_PAETH: pred = paeth;
         default:    pred = '0;
      endcase
   end

   assign pix = s1_op_ff.raw_byte + pred;

   always_comb begin
      for (int i = 0; i < BYTES_PER_PIXEL; i++) begin
         left_in[i] = left_ff[i];
         up_in[i]   = up_ff[i];
      end
      if (wr_en) begin
         for (int i = 0; i < BYTES_PER_PIXEL - 1; i++) begin
            left_in[i] = left_eff[i+1];
            up_in[i]   = up_eff[i+1];
         end
         left_in[BYTES_PER_PIXEL-1] = pix;
         up_in[BYTES_PER_PIXEL-1]   = b;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (ld) begin
         s1_valid_in = 1'b1;
      end else if (can_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (wr_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.pixel_byte = rsp_pixel_ff;
   assign rsp_ch.line_end   = rsp_end_ff;

   // previous-row line buffer, one read and one write port
   always_ff @(posedge clock) begin
      if (ld) begin
         rd_data_ff <= row_mem[rd_addr];
      end
      if (wr_en) begin
         row_mem[s1_col_ff] <= pix;
      end
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         fwd_ff      <= fwd_in;
         fwd_data_ff <= pix;
         s1_op_ff    <= op_in;
         s1_col_ff   <= rd_addr;
      end
      if (wr_en) begin
         rsp_pixel_ff <= pix;
         rsp_end_ff   <= s1_op_ff.last;
      end
      left_ff <= left_in;
      up_ff   <= up_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_load_into_free_stage: assert property (@(posedge clock) disable iff (reset)
      ld |-> !s1_valid_ff || can_adv)
      else $error("stage loaded while holding an unsent word");

   a_fresh_at_col_zero: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_op_ff.fresh |-> s1_col_ff == '0)
      else $error("line start not at column zero");

   a_write_makes_result: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rsp_valid_ff && rsp_pixel_ff == $past(pix))
      else $error("reconstructed byte not presented");

endmodule

/* hw/rtl/png_scanline_unfilter.sv */
// channel  dir  payload                   handshake
// req_ch   in   raw_byte[7:0] image_start valid/ready
// rsp_ch   out  pixel_byte[7:0] line_end  valid/ready
// csr_ch   in   line_bytes[13:0]          valid/ready, ready always high
//
// one word per cycle unless rsp_ch stalls; data passes reconstruct stage then output register
// the previous-row buffer is one memory, read at acceptance, written from the reconstruct stage
// filter type words are consumed with no result
// reset clears control only; the row buffer holds nothing valid until the first row is written
// a stalled rsp_ch holds one word in the output register and one in the reconstruct stage
module png_scanline_unfilter #(
   parameter int MAX_WIDTH       = psu_pkg::MAX_WIDTH_DEF,
   parameter int BYTES_PER_PIXEL = psu_pkg::BPP_DEF
) (
   input logic       clock,
   input logic       reset,
   psu_req_if.sink   req_ch,
   psu_rsp_if.source rsp_ch,
   psu_csr_if.sink   csr_ch
);
   import psu_pkg::*;

   localparam int CAP = row_cap(MAX_WIDTH, BYTES_PER_PIXEL);
   localparam int AW  = addr_w(CAP);

   logic          ld;
   logic          s1_ready;
   psu_op_type    op;
   logic [AW-1:0] rd_addr;

   psu_seq #(
      .MAX_WIDTH       (MAX_WIDTH),
      .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .csr_ch   (csr_ch),
      .s1_ready (s1_ready),
      .ld       (ld),
      .op       (op),
      .rd_addr  (rd_addr)
   );

   psu_recon #(
      .MAX_WIDTH       (MAX_WIDTH),
      .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
   ) u_recon (
      .clock    (clock),
      .reset    (reset),
      .ld       (ld),
      .op_in    (op),
      .rd_addr  (rd_addr),
      .s1_ready (s1_ready),
      .rsp_ch   (rsp_ch)
   );

endmodule

/* tb/png_scanline_unfilter_tb.sv */
`timescale 1ns / 1ps

module png_scanline_unfilter_tb;
   import psu_pkg::*;

   localparam int ROW_CAP = MAX_WIDTH_DEF * BPP_DEF;
   localparam int QUIET_CYCLES = 6;
   localparam int HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int STAGE_WORDS = 200;
   localparam int PRINT_CAP = 200;
   localparam logic [RAW_W-1:0] UNKNOWN_FILTER = 8'hFF;
   localparam logic [LINE_W-1:0] LINE_SATURATE = '1;

   typedef struct packed {
      logic [RAW_W-1:0] pixel;
      logic             line_end;
   } pixel_word_type;

   class pixel_scoreboard_type;
      logic [RAW_W-1:0]  prior_row [ROW_CAP];
      bit                row_written [ROW_CAP];
      int unsigned       extent;
      logic [RAW_W-1:0]  left_bytes [BPP_DEF];
      logic [RAW_W-1:0]  upper_bytes [BPP_DEF];
      int unsigned       column;
      filter_kind_type   kind;
      bit                want_filter;
      bit                first_row;
      logic [LINE_W-1:0] line_reg;
      pixel_word_type    pending_pixels [$];
      int                errors;
      int                results;
      int                lines;
      int                settings;
      int                kinds_seen [6];

      function new();
         line_reg = LINE_W'(LINE_RESET);
         want_filter = 1'b1;
         first_row = 1'b1;
         kind = FILT_NONE;
         column = 0;
         extent = 0;
         clear_history();
      endfunction

      function void clear_history();
         for (int i = 0; i < BPP_DEF; i++) begin
            left_bytes[i] = '0;
            upper_bytes[i] = '0;
         end
      endfunction

      function int unsigned length_for(logic [LINE_W-1:0] value);
         if (value == 0)
            return 1;
         if (value > ROW_CAP)
            return ROW_CAP;
         return value;
      endfunction

      function int unsigned row_extent();
         return extent;
      endfunction

      function int pending();
         return pending_pixels.size();
      endfunction

      function void note_config(logic [LINE_W-1:0] value);
         line_reg = value;
         settings++;
      endfunction

      function logic [RAW_W-1:0] paeth_pick(int a, int b, int c);
         int p, pa, pb, pc;
         p = a + b - c;
         pa = (p > a) ? p - a : a - p;
         pb = (p > b) ? p - b : b - p;
         pc = (p > c) ? p - c : c - p;
         if (pa <= pb && pa <= pc)
            return 8'(a);
         if (pb <= pc)
            return 8'(b);
         return 8'(c);
      endfunction

      function void note_input(logic [RAW_W-1:0] raw, logic start);
         int unsigned      len, col;
         int               a, b, c;
         logic [RAW_W-1:0] guess, pix;
         pixel_word_type   word;
         len = length_for(line_reg);
         if (start) begin
            want_filter = 1'b1;
            first_row = 1'b1;
            column = 0;
         end
         if (want_filter) begin
            if (raw <= 8'(FILT_PAETH)) begin
               kind = filter_kind_type'(raw[2:0]);
               kinds_seen[int'(raw)]++;
            end else begin
               kind = FILT_NONE;
               kinds_seen[5]++;
            end
            want_filter = 1'b0;
            column = 0;
            clear_history();
            return;
         end
         col = (column >= len) ? len - 1 : column;
         a = left_bytes[0];
         c = upper_bytes[0];
         b = first_row ? 0 : prior_row[col];
         case (kind)
            FILT_SUB:   guess = 8'(a);
            FILT_UP:    guess = 8'(b);
            FILT_AVG:   guess = 8'((a + b) >> 1);
            FILT_PAETH: guess = paeth_pick(a, b, c);
            default:    guess = '0;
         endcase
         pix = raw + guess;
         for (int i = 0; i + 1 < BPP_DEF; i++) begin
            left_bytes[i] = left_bytes[i + 1];
            upper_bytes[i] = upper_bytes[i + 1];
         end
         left_bytes[BPP_DEF-1] = pix;
         upper_bytes[BPP_DEF-1] = 8'(b);
         prior_row[col] = pix;
         row_written[col] = 1'b1;
         while (extent < ROW_CAP && row_written[extent])
            extent++;
         word.pixel = pix;
         word.line_end = (col + 1 >= len);
         if (word.line_end) begin
            want_filter = 1'b1;
            first_row = 1'b0;
            column = 0;
         end else begin
            column = col + 1;
         end
         pending_pixels.push_back(word);
      endfunction

      task report(string what);
         if (errors < PRINT_CAP)
            $display("mismatch at word %0d: %s", results, what);
         errors++;
      endtask

      task check_result(logic [RAW_W-1:0] pix, logic line_end);
         pixel_word_type word;
         if (pending_pixels.size() == 0) begin
            report($sformatf("unexpected word pixel %02h line_end %0b", pix, line_end));
            return;
         end
         word = pending_pixels.pop_front();
         if (pix !== word.pixel)
            report($sformatf("pixel_byte %02h, wanted %02h", pix, word.pixel));
         if (line_end !== word.line_end)
            report($sformatf("line_end %0b, wanted %0b", line_end, word.line_end));
         if (word.line_end)
            lines++;
         results++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   psu_req_if req_ch();
   psu_rsp_if rsp_ch();
   psu_csr_if csr_ch();

   png_scanline_unfilter DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   pixel_scoreboard_type board;
   int              send_gap_pct = 0;
   int              rsp_gap_pct = 0;
   bit              stall_request = 1'b0;
   int unsigned     words_sent = 0;
   int              quiet_run = 0;
   bit              moved;

   always @(posedge clock) begin
      if (reset) begin
         quiet_run = 0;
      end else begin
         moved = 1'b0;
         if (csr_ch.valid && csr_ch.ready) begin
            board.note_config(csr_ch.line_bytes);
            moved = 1'b1;
         end
         if (req_ch.valid && req_ch.ready) begin
            board.note_input(req_ch.raw_byte, req_ch.image_start);
            moved = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            board.check_result(rsp_ch.pixel_byte, rsp_ch.line_end);
            moved = 1'b1;
         end
         quiet_run = moved ? 0 : quiet_run + 1;
         if (quiet_run >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // receiver: random back-pressure, or a long hold on request
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_gap_pct);
      end
   end

   task send_word(input logic [RAW_W-1:0] value, input logic start);
      while ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.raw_byte <= value;
      req_ch.image_start <= start;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      words_sent++;
   endtask

   task write_line_bytes(input logic [LINE_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.line_bytes <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
   endtask

   task wait_quiet();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   function automatic logic [RAW_W-1:0] pick_filter();
      if ($urandom_range(7) == 0)
         return 8'($urandom_range(255, 5));
      return 8'($urandom_range(4));
   endfunction

   function automatic logic [LINE_W-1:0] pick_length();
      case ($urandom_range(3))
         0:       return 14'($urandom_range(1, 6));
         1:       return 14'(3 * $urandom_range(2, 8));
         2:       return 14'($urandom_range(7, 40));
         default: return 14'(3 * $urandom_range(10, 40));
      endcase
   endfunction

   task send_fixed_row(input logic [RAW_W-1:0] filt, input logic start,
                       input logic [RAW_W-1:0] d0, input logic [RAW_W-1:0] d1,
                       input logic [RAW_W-1:0] d2, input logic [RAW_W-1:0] d3);
      send_word(filt, start);
      send_word(d0, 1'b0);
      send_word(d1, 1'b0);
      send_word(d2, 1'b0);
      send_word(d3, 1'b0);
   endtask

   // a stray image_start now and then breaks the line up
   task send_random_row(input int unsigned n, input logic start);
      send_word(pick_filter(), start);
      for (int i = 0; i < n; i++)
         send_word(8'($urandom), $urandom_range(199) == 0);
   endtask

   task run_phase(input logic [LINE_W-1:0] len, input int rows, input bit hold);
      int unsigned n;
      logic        start;
      wait_quiet();
      write_line_bytes(len);
      n = board.length_for(len);
      start = (n > board.row_extent()) || ($urandom_range(2) == 0);
      if (hold)
         stall_request = 1'b1;
      for (int r = 0; r < rows; r++) begin
         send_random_row(n, start);
         start = ($urandom_range(11) == 0);
      end
   endtask

   // shorten the line while one is half sent
   task cut_line(input logic [LINE_W-1:0] len, input int keep, input logic [LINE_W-1:0] new_len);
      int unsigned n, m, rest;
      wait_quiet();
      write_line_bytes(len);
      n = board.length_for(len);
      send_random_row(n, 1'b1);
      send_word(pick_filter(), 1'b0);
      for (int i = 0; i < keep; i++)
         send_word(8'($urandom), 1'b0);
      wait_quiet();
      write_line_bytes(new_len);
      m = board.length_for(new_len);
      rest = (keep >= m) ? 1 : m - keep;
      for (int i = 0; i < rest; i++)
         send_word(8'($urandom), 1'b0);
      send_random_row(m, 1'b0);
      send_random_row(m, 1'b0);
   endtask

   initial begin
      int unsigned target;
      board = new();
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.raw_byte <= '0;
      req_ch.image_start <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.line_bytes <= LINE_W'(LINE_RESET);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_line_bytes(14'd4);
      send_fixed_row(FILT_PAETH, 1'b1, 8'h00, 8'hFF, 8'h80, 8'h7F);
      send_fixed_row(FILT_SUB, 1'b0, 8'hFF, 8'h01, 8'h7F, 8'h80);
      send_fixed_row(FILT_UP, 1'b0, 8'h00, 8'hFF, 8'h01, 8'hFE);
      send_fixed_row(FILT_AVG, 1'b0, 8'hFF, 8'hFF, 8'h00, 8'h80);
      send_fixed_row(FILT_PAETH, 1'b0, 8'h80, 8'h7F, 8'h00, 8'hFF);
      send_fixed_row(UNKNOWN_FILTER, 1'b0, 8'h01, 8'h02, 8'hFE, 8'hFF);
      send_fixed_row(FILT_NONE, 1'b0, 8'h55, 8'hAA, 8'h0F, 8'hF0);

      for (int stage = 0; stage < 3; stage++) begin
         case (stage)
            0: begin
               send_gap_pct = 37;
               rsp_gap_pct = 67;
            end
            1: begin
               send_gap_pct = 67;
               rsp_gap_pct = 37;
            end
            default: begin
               send_gap_pct = 0;
               rsp_gap_pct = 0;
            end
         endcase
         target = words_sent + STAGE_WORDS;
         case (stage)
            0: begin
               run_phase(LINE_W'(LINE_RESET), 3, 1'b0);
               run_phase(14'd0, 4, 1'b0);
               cut_line(14'd30, 20, 14'd6);
            end
            1: begin
               run_phase(14'd48, 3, 1'b1);
               cut_line(14'd60, 10, 14'd24);
            end
            default: begin
               cut_line(14'd48, 23, 14'd24);
            end
         endcase
         while (words_sent < target)
            run_phase(pick_length(), $urandom_range(2, 6), $urandom_range(15) == 0);
      end

      // oversized length: a long partial line, then cut short by a small length
      wait_quiet();
      write_line_bytes(LINE_SATURATE);
      send_random_row(24, 1'b1);
      run_phase(14'd1, 3, 1'b0);
      run_phase(14'd2, 4, 1'b0);

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (2 * QUIET_CYCLES) @(posedge clock);
      $display("checked %0d pixel words in %0d scanlines over %0d line length settings",
               board.results, board.lines, board.settings);
      $display("filter bytes none/sub/up/average/paeth/unknown: %0d/%0d/%0d/%0d/%0d/%0d",
               board.kinds_seen[0], board.kinds_seen[1], board.kinds_seen[2],
               board.kinds_seen[3], board.kinds_seen[4], board.kinds_seen[5]);
      if (board.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
